### rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and microprogram of the date counter
// Holds field widths, command and micro-op codes, the month length table and
// the read-only control store that sequences every command.
// ----------------------------------------------------------------------------
package gda_pkg;

	// Default width of the day counter
	localparam int COUNT_BITS_DEF = 16;

	// Field widths
	localparam int CMD_W = 3;
	localparam int YEAR_W = 14;
	localparam int YI_W = 14;
	localparam int MI_W = 8;
	localparam int DI_W = 16;
	localparam int DC_W = 16;
	localparam int MON_W = 4;
	localparam int DAY_W = 5;

	// Working register widths (signed)
	localparam int WY_W = 16;
	localparam int WM_W = 10;
	localparam int WD_W = 18;

	// Year modulo 400 by reciprocal multiply
	localparam int R_W = 9;
	localparam int ABS_W = 15;
	localparam int PROD_W = 32;
	localparam int RECIP_S = 25;
	localparam int Q_W = PROD_W - RECIP_S;
	localparam logic [PROD_W-1:0] RECIP_K = 32'd83887;
	localparam logic [R_W-1:0] YEAR_CYCLE = 9'd400;
	localparam logic [R_W-1:0] CENT_1 = 9'd100;
	localparam logic [R_W-1:0] CENT_2 = 9'd200;
	localparam logic [R_W-1:0] CENT_3 = 9'd300;
	localparam logic [R_W-1:0] CYCLE_LAST = 9'd399;

	// Date limits and reset date
	localparam int YEAR_MIN = 1;
	localparam int YEAR_MAX = 9999;
	localparam logic [YEAR_W-1:0] YEAR_RST = 14'd1900;
	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_APR = 4'd4;
	localparam logic [MON_W-1:0] MON_JUN = 4'd6;
	localparam logic [MON_W-1:0] MON_SEP = 4'd9;
	localparam logic [MON_W-1:0] MON_NOV = 4'd11;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;
	localparam logic [DAY_W-1:0] DAY_ONE = 5'd1;
	localparam int MONTHS = 12;

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEXT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PREV = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_DAYS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SUB_DAYS = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ADD_OFS = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SUB_OFS = 3'd6;

	typedef logic [3:0] op_t;
	typedef logic [3:0] cond_t;
	typedef logic [4:0] pc_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		pc_t target;
		logic hold;
	} uword_t;

	// Micro-ops
	localparam op_t OP_NOP = 4'd0;
	localparam op_t OP_LOAD = 4'd1;
	localparam op_t OP_CUR = 4'd2;
	localparam op_t OP_ADDOFF = 4'd3;
	localparam op_t OP_SUBOFF = 4'd4;
	localparam op_t OP_DFLT = 4'd5;
	localparam op_t OP_MNORM = 4'd6;
	localparam op_t OP_MUL = 4'd7;
	localparam op_t OP_MOD = 4'd8;
	localparam op_t OP_FWD = 4'd9;
	localparam op_t OP_BWD = 4'd10;
	localparam op_t OP_ADDD = 4'd11;
	localparam op_t OP_SUBD = 4'd12;
	localparam op_t OP_COMMIT = 4'd13;

	// Branch conditions; a real condition that holds skips the op and jumps
	localparam cond_t C_NEXT = 4'd0;
	localparam cond_t C_JUMP = 4'd1;
	localparam cond_t C_CMD = 4'd2;
	localparam cond_t C_FWDCMD = 4'd3;
	localparam cond_t C_LDOK = 4'd4;
	localparam cond_t C_MOK = 4'd5;
	localparam cond_t C_DFIT = 4'd6;
	localparam cond_t C_DPOS = 4'd7;
	localparam cond_t C_ADONE = 4'd8;
	localparam cond_t C_SDONE = 4'd9;

	// Step addresses
	localparam pc_t PC_DISPATCH = 5'd0;
	localparam pc_t PC_LOAD = 5'd1;
	localparam pc_t PC_LMUL = 5'd2;
	localparam pc_t PC_LMOD = 5'd3;
	localparam pc_t PC_LCHK = 5'd4;
	localparam pc_t PC_COMMIT = 5'd5;
	localparam pc_t PC_CUR = 5'd6;
	localparam pc_t PC_CMUL = 5'd7;
	localparam pc_t PC_CMOD = 5'd8;
	localparam pc_t PC_CSEL = 5'd9;
	localparam pc_t PC_SUBLOOP = 5'd10;
	localparam pc_t PC_ADDLOOP = 5'd11;
	localparam pc_t PC_ADDOFF = 5'd12;
	localparam pc_t PC_SUBOFF = 5'd13;
	localparam pc_t PC_MNORM = 5'd14;
	localparam pc_t PC_OMUL = 5'd15;
	localparam pc_t PC_OMOD = 5'd16;
	localparam pc_t PC_FWD = 5'd17;
	localparam pc_t PC_BWD = 5'd18;
	localparam pc_t PC_KEEP = 5'd19;

	function automatic logic [DAY_W-1:0] mlen(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic uword_t uw(input op_t op, input cond_t cond, input pc_t target,
			input logic hold);
		uword_t w;
		w.op = op;
		w.cond = cond;
		w.target = target;
		w.hold = hold;
		return w;
	endfunction

	// Control store
	function automatic uword_t urom(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_DISPATCH: w = uw(OP_NOP, C_CMD, PC_DISPATCH, 1'b0);
			PC_LOAD: w = uw(OP_LOAD, C_NEXT, PC_DISPATCH, 1'b0);
			PC_LMUL: w = uw(OP_MUL, C_NEXT, PC_DISPATCH, 1'b0);
			PC_LMOD: w = uw(OP_MOD, C_NEXT, PC_DISPATCH, 1'b0);
			PC_LCHK: w = uw(OP_DFLT, C_LDOK, PC_COMMIT, 1'b0);
			PC_COMMIT: w = uw(OP_COMMIT, C_NEXT, PC_DISPATCH, 1'b0);
			PC_CUR: w = uw(OP_CUR, C_NEXT, PC_DISPATCH, 1'b0);
			PC_CMUL: w = uw(OP_MUL, C_NEXT, PC_DISPATCH, 1'b0);
			PC_CMOD: w = uw(OP_MOD, C_NEXT, PC_DISPATCH, 1'b0);
			PC_CSEL: w = uw(OP_NOP, C_FWDCMD, PC_ADDLOOP, 1'b0);
			PC_SUBLOOP: w = uw(OP_SUBD, C_SDONE, PC_COMMIT, 1'b1);
			PC_ADDLOOP: w = uw(OP_ADDD, C_ADONE, PC_COMMIT, 1'b1);
			PC_ADDOFF: w = uw(OP_ADDOFF, C_JUMP, PC_MNORM, 1'b0);
			PC_SUBOFF: w = uw(OP_SUBOFF, C_NEXT, PC_DISPATCH, 1'b0);
			PC_MNORM: w = uw(OP_MNORM, C_MOK, PC_OMUL, 1'b1);
			PC_OMUL: w = uw(OP_MUL, C_NEXT, PC_DISPATCH, 1'b0);
			PC_OMOD: w = uw(OP_MOD, C_NEXT, PC_DISPATCH, 1'b0);
			PC_FWD: w = uw(OP_FWD, C_DFIT, PC_BWD, 1'b1);
			PC_BWD: w = uw(OP_BWD, C_DPOS, PC_COMMIT, 1'b1);
			PC_KEEP: w = uw(OP_CUR, C_JUMP, PC_COMMIT, 1'b0);
			default: w = uw(OP_NOP, C_JUMP, PC_COMMIT, 1'b0);
		endcase
		return w;
	endfunction

	// First step of each command
	function automatic pc_t entry(input logic [CMD_W-1:0] cmd);
		pc_t pc;
		unique case (cmd)
			CMD_LOAD: pc = PC_LOAD;
			CMD_NEXT, CMD_PREV, CMD_ADD_DAYS, CMD_SUB_DAYS: pc = PC_CUR;
			CMD_ADD_OFS: pc = PC_ADDOFF;
			CMD_SUB_OFS: pc = PC_SUBOFF;
			default: pc = PC_KEEP;
		endcase
		return pc;
	endfunction

endpackage

### rtl/gda_if.sv
// ----------------------------------------------------------------------------
// gda_if: command and result channels of the date counter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gda_in_if;
	import gda_pkg::*;

	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [YI_W-1:0] year_in;
	logic [MI_W-1:0] month_in;
	logic [DI_W-1:0] day_in;
	logic [DC_W-1:0] day_count;

	modport source (output valid, cmd, year_in, month_in, day_in, day_count, input ready);
	modport sink (input valid, cmd, year_in, month_in, day_in, day_count, output ready);
endinterface

interface gda_out_if;
	import gda_pkg::*;

	logic valid;
	logic ready;
	logic [YEAR_W-1:0] year_out;
	logic [MON_W-1:0] month_out;
	logic [DAY_W-1:0] day_out;
	logic range_error;

	modport source (output valid, year_out, month_out, day_out, range_error, input ready);
	modport sink (input valid, year_out, month_out, day_out, range_error, output ready);
endinterface

### rtl/gregorian_date_arithmetic.sv
// Sequence: load takes the fields, finds the year mod 400 and checks the date;
//   next/previous day and add/subtract days walk the held date month by month;
//   offsets add or subtract the fields, normalize the month, then roll the day over.
// Throughput: one command at a time; the month walk in the shared day/month datapath
//   dominates it. A new beat is taken while the last result waits at the output.
// Reset: arst_n clears the sequencer and output valid and sets the date to 1900-01-01.
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic: microcoded Gregorian date counter
// A small control store steps a working date (year, month, day) through load,
// day walks and offset normalization, then commits it or flags a range error.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic #(
	parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	gda_in_if.sink item,
	gda_out_if.source result
);
	import gda_pkg::*;

	// Sequencer
	logic busy_q;
	pc_t pc_q;
	pc_t pc_nxt;
	uword_t uw_c;
	logic take;
	logic exec;
	logic do_op;
	logic commit;
	logic accept;

	// Captured command fields
	logic [CMD_W-1:0] cmd_q;
	logic [YI_W-1:0] yi_q;
	logic [MI_W-1:0] mi_q;
	logic [DI_W-1:0] di_q;
	logic [COUNT_BITS-1:0] n_q;

	// Working date, signed so that offsets may run below zero
	logic signed [WY_W-1:0] y_q;
	logic signed [WM_W-1:0] m_q;
	logic signed [WD_W-1:0] d_q;
	logic [R_W-1:0] r400_q;
	logic [PROD_W-1:0] prod_q;

	// Held date
	logic [YEAR_W-1:0] cur_year_q;
	logic [MON_W-1:0] cur_month_q;
	logic [DAY_W-1:0] cur_day_q;

	// Output register
	logic out_valid_q;
	logic [YEAR_W-1:0] out_year_q;
	logic [MON_W-1:0] out_month_q;
	logic [DAY_W-1:0] out_day_q;
	logic out_err_q;

	// Datapath helpers
	logic leap;
	logic [MON_W-1:0] m_idx;
	logic [MON_W-1:0] m_prev;
	logic [DAY_W-1:0] len_cur;
	logic [DAY_W-1:0] len_prev;
	logic [DAY_W-1:0] room;
	logic [ABS_W-1:0] y_abs;
	logic [Q_W-1:0] quot;
	logic [ABS_W-1:0] rem_w;
	logic [R_W-1:0] rem;
	logic [R_W-1:0] r400_inc;
	logic [R_W-1:0] r400_dec;
	logic y_ok;
	logic m_ok;

	assign accept = item.valid && item.ready;
	assign item.ready = !busy_q;

	assign result.valid = out_valid_q;
	assign result.year_out = out_year_q;
	assign result.month_out = out_month_q;
	assign result.day_out = out_day_q;
	assign result.range_error = out_err_q;

	// Leap test from the year's residue mod 400: divisible by 4, and not a
	// century unless the residue is zero
	assign leap = (r400_q[1:0] == 2'b00) && (r400_q != CENT_1) && (r400_q != CENT_2)
			&& (r400_q != CENT_3);
	assign m_idx = m_q[MON_W-1:0];
	assign m_prev = (m_idx == MON_JAN) ? MON_DEC : m_idx - MON_JAN;
	assign len_cur = mlen(m_idx, leap);
	// Stepping back into December never needs the new year's leap flag
	assign len_prev = mlen(m_prev, leap);
	assign room = len_cur - d_q[DAY_W-1:0];

	assign r400_inc = (r400_q == CYCLE_LAST) ? '0 : r400_q + R_W'(1);
	assign r400_dec = (r400_q == '0) ? CYCLE_LAST : r400_q - R_W'(1);

	// Year mod 400: reciprocal multiply registered in one step, remainder in the next
	assign y_abs = (y_q < 0) ? ABS_W'(-y_q) : ABS_W'(y_q);
	assign quot = prod_q[PROD_W-1:RECIP_S];
	assign rem_w = y_abs - ABS_W'(ABS_W'(quot) * ABS_W'(YEAR_CYCLE));
	assign rem = rem_w[R_W-1:0];

	assign y_ok = (y_q >= YEAR_MIN) && (y_q <= YEAR_MAX);
	assign m_ok = (m_q >= 1) && (m_q <= MONTHS);

	// Control word decode and branch
	always_comb begin
		uw_c = urom(pc_q);
		pc_nxt = pc_q + pc_t'(1);
		take = 1'b0;
		exec = 1'b1;
		unique case (uw_c.cond)
			C_NEXT: begin
				take = 1'b0;
			end
			C_JUMP: begin
				take = 1'b1;
			end
			C_CMD: begin
				take = 1'b1;
			end
			C_FWDCMD: begin
				take = (cmd_q == CMD_NEXT) || (cmd_q == CMD_ADD_DAYS);
			end
			C_LDOK: begin
				take = m_ok && (d_q >= 1) && (d_q <= $signed({1'b0, len_cur}));
				exec = !take;
			end
			C_MOK: begin
				take = m_ok;
				exec = !take;
			end
			C_DFIT: begin
				take = d_q <= $signed({1'b0, len_cur});
				exec = !take;
			end
			C_DPOS: begin
				take = d_q >= 1;
				exec = !take;
			end
			C_ADONE: begin
				take = (n_q == '0) || (y_q > YEAR_MAX);
				exec = !take;
			end
			C_SDONE: begin
				take = (n_q == '0) || (y_q < YEAR_MIN);
				exec = !take;
			end
			default: begin
				take = 1'b1;
			end
		endcase
		if (take) begin
			pc_nxt = (uw_c.cond == C_CMD) ? entry(cmd_q) : uw_c.target;
		end else if (uw_c.hold) begin
			pc_nxt = pc_q;
		end
	end

	// Commit waits for the output register to be free
	assign commit = busy_q && (uw_c.op == OP_COMMIT) && (!out_valid_q || result.ready);
	assign do_op = busy_q && exec && (uw_c.op != OP_COMMIT);

	// Control state and held date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= PC_DISPATCH;
			out_valid_q <= 1'b0;
			cur_year_q <= YEAR_RST;
			cur_month_q <= MON_JAN;
			cur_day_q <= DAY_ONE;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				pc_q <= PC_DISPATCH;
			end else if (commit) begin
				busy_q <= 1'b0;
				// Keep the date when the year left the legal range
				if (y_ok) begin
					cur_year_q <= y_q[YEAR_W-1:0];
					cur_month_q <= m_q[MON_W-1:0];
					cur_day_q <= d_q[DAY_W-1:0];
				end
			end else if (busy_q && (uw_c.op != OP_COMMIT)) begin
				pc_q <= pc_nxt;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_year_q <= y_ok ? y_q[YEAR_W-1:0] : cur_year_q;
			out_month_q <= y_ok ? m_q[MON_W-1:0] : cur_month_q;
			out_day_q <= y_ok ? d_q[DAY_W-1:0] : cur_day_q;
			out_err_q <= !y_ok;
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.cmd;
			yi_q <= item.year_in;
			mi_q <= item.month_in;
			di_q <= item.day_in;
			// Single-day steps walk a count of one
			n_q <= ((item.cmd == CMD_NEXT) || (item.cmd == CMD_PREV))
					? COUNT_BITS'(1) : COUNT_BITS'(item.day_count);
		end else if (do_op) begin
			unique case (uw_c.op)
				OP_LOAD: begin
					y_q <= signed'(WY_W'(yi_q));
					m_q <= signed'(WM_W'(mi_q));
					d_q <= signed'(WD_W'(di_q));
				end
				OP_CUR: begin
					y_q <= signed'(WY_W'(cur_year_q));
					m_q <= signed'(WM_W'(cur_month_q));
					d_q <= signed'(WD_W'(cur_day_q));
				end
				OP_ADDOFF: begin
					y_q <= signed'(WY_W'(cur_year_q)) + signed'(WY_W'(yi_q));
					m_q <= signed'(WM_W'(cur_month_q)) + signed'(WM_W'(mi_q));
					d_q <= signed'(WD_W'(cur_day_q)) + signed'(WD_W'(di_q));
				end
				OP_SUBOFF: begin
					y_q <= signed'(WY_W'(cur_year_q)) - signed'(WY_W'(yi_q));
					m_q <= signed'(WM_W'(cur_month_q)) - signed'(WM_W'(mi_q));
					d_q <= signed'(WD_W'(cur_day_q)) - signed'(WD_W'(di_q));
				end
				OP_DFLT: begin
					y_q <= signed'(WY_W'(YEAR_RST));
					m_q <= signed'(WM_W'(MON_JAN));
					d_q <= signed'(WD_W'(DAY_ONE));
				end
				OP_MNORM: begin
					// Bring the month into range, carrying into the year
					if (m_q > MONTHS) begin
						m_q <= m_q - WM_W'(MONTHS);
						y_q <= y_q + WY_W'(1);
					end else begin
						m_q <= m_q + WM_W'(MONTHS);
						y_q <= y_q - WY_W'(1);
					end
				end
				OP_MUL: begin
					prod_q <= PROD_W'(y_abs) * RECIP_K;
				end
				OP_MOD: begin
					r400_q <= ((y_q < 0) && (rem != '0)) ? YEAR_CYCLE - rem : rem;
				end
				OP_FWD: begin
					d_q <= d_q - signed'(WD_W'(len_cur));
					if (m_idx == MON_DEC) begin
						m_q <= signed'(WM_W'(MON_JAN));
						y_q <= y_q + WY_W'(1);
						r400_q <= r400_inc;
					end else begin
						m_q <= m_q + WM_W'(1);
					end
				end
				OP_BWD: begin
					d_q <= d_q + signed'(WD_W'(len_prev));
					m_q <= signed'(WM_W'(m_prev));
					if (m_idx == MON_JAN) begin
						y_q <= y_q - WY_W'(1);
						r400_q <= r400_dec;
					end
				end
				OP_ADDD: begin
					if (n_q <= COUNT_BITS'(room)) begin
						d_q <= d_q + signed'(WD_W'(n_q[DAY_W-1:0]));
						n_q <= '0;
					end else begin
						// Spend the rest of this month, land on the 1st of the next
						n_q <= n_q - COUNT_BITS'(room) - COUNT_BITS'(1);
						d_q <= signed'(WD_W'(DAY_ONE));
						if (m_idx == MON_DEC) begin
							m_q <= signed'(WM_W'(MON_JAN));
							y_q <= y_q + WY_W'(1);
							r400_q <= r400_inc;
						end else begin
							m_q <= m_q + WM_W'(1);
						end
					end
				end
				OP_SUBD: begin
					if (n_q < COUNT_BITS'(d_q[DAY_W-1:0])) begin
						d_q <= d_q - signed'(WD_W'(n_q[DAY_W-1:0]));
						n_q <= '0;
					end else begin
						// Drop to the last day of the previous month
						n_q <= n_q - COUNT_BITS'(d_q[DAY_W-1:0]);
						d_q <= signed'(WD_W'(len_prev));
						m_q <= signed'(WM_W'(m_prev));
						if (m_idx == MON_JAN) begin
							y_q <= y_q - WY_W'(1);
							r400_q <= r400_dec;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/gda_checker.sv
// ----------------------------------------------------------------------------
// gda_checker: port-level checks of the date counter
// Watches the command and result channels and the dates the block returns.
// ----------------------------------------------------------------------------
module gda_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [gda_pkg::YEAR_W-1:0] year,
	input logic [gda_pkg::MON_W-1:0] month,
	input logic [gda_pkg::DAY_W-1:0] day,
	input logic err
);
	import gda_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({year, month, day, err}))
		else $error("result beat changed while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in flight");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= MON_JAN) && (month <= MON_DEC) && (day >= DAY_ONE)
			&& (year >= YEAR_W'(YEAR_MIN)) && (year <= YEAR_W'(YEAR_MAX)))
		else $error("returned date out of range");

	a_short_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((month == MON_APR) || (month == MON_JUN) || (month == MON_SEP)
			|| (month == MON_NOV)) |-> day <= 5'd30)
		else $error("day beyond a 30-day month");

	a_february: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (month == MON_FEB) |-> day <= 5'd29)
		else $error("day beyond February");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.year(result.year_out),
	.month(result.month_out),
	.day(result.day_out),
	.err(result.range_error)
);
